FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the GC content block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCCP_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define GCCP_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

FILE: rtl/gccp_pkg.sv
package gccp_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int FRAC_BITS   = 16;
    localparam int QUOT_BITS   = FRAC_BITS + 2;
    localparam int STEP_BITS   = $clog2(QUOT_BITS);
    localparam int NUM_BITS    = COUNT_BITS + 2;
    localparam int EN_BITS     = 4;
    localparam int ALL_BITS    = FRAC_BITS + 1;
    localparam int POS_BITS    = FRAC_BITS + 2;
    localparam int STATUS_BITS = 2;
    localparam int BASE_BITS   = 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [EN_BITS-1:0]    EN_RESET   = '1;

    localparam logic [BASE_BITS-1:0] CHAR_C_UPPER = 8'h43;
    localparam logic [BASE_BITS-1:0] CHAR_C_LOWER = 8'h63;
    localparam logic [BASE_BITS-1:0] CHAR_G_UPPER = 8'h47;
    localparam logic [BASE_BITS-1:0] CHAR_G_LOWER = 8'h67;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_LOAD,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_ALL,
        DIV_FIRST,
        DIV_SECOND,
        DIV_THIRD
    } div_sel_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK,
        STATUS_NO_STAT,
        STATUS_EMPTY,
        STATUS_SATURATED
    } status_t;

    typedef struct packed {
        logic     count;
        logic     load;
        logic     step;
        logic     store;
        logic     publish;
        div_sel_t sel;
    } dp_cmd_t;

    function automatic logic is_gc(input logic [BASE_BITS-1:0] ch);
        return (ch == CHAR_C_UPPER) || (ch == CHAR_C_LOWER) ||
               (ch == CHAR_G_UPPER) || (ch == CHAR_G_LOWER);
    endfunction

endpackage

FILE: rtl/gc_content_by_codon_position_top.sv
// GC content of a nucleotide sequence, overall and at each codon position.
// The input channel (in_valid, in_stall) carries one ASCII character per word
// in base, with last set on the final character of the sequence. Characters
// other than the final one are taken one per cycle.
// On the final character the input stalls while four fractions are worked
// out one after another by a single restoring divider, one quotient bit per
// cycle. The result word appears on the output channel (out_valid,
// out_stall) once all four fractions are stored and the output register is
// free, and the next sequence may start after the word is published.
// A result word that the receiver stalls is held unchanged in the output
// register; the next sequence is taken meanwhile, but its own result waits
// until the held word has gone.
// The configuration channel (cfg_valid, cfg_ready) writes the statistic
// enable mask in stat_enable and is always ready; write it only while idle.
// Reset clears all counts, empties the output register and enables every
// statistic.
module gc_content_by_codon_position_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gccp_pkg::EN_BITS-1:0]         stat_enable,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [gccp_pkg::BASE_BITS-1:0]       base,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [gccp_pkg::ALL_BITS-1:0]        gc_all,
    output logic [gccp_pkg::POS_BITS-1:0]        gc_first,
    output logic [gccp_pkg::POS_BITS-1:0]        gc_second,
    output logic [gccp_pkg::POS_BITS-1:0]        gc_third,
    output logic [gccp_pkg::STATUS_BITS-1:0]     status
);
    import gccp_pkg::*;

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    gccp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    gccp_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_write (cfg_valid),
        .cfg_data  (stat_enable),
        .base      (base),
        .gc_all    (gc_all),
        .gc_first  (gc_first),
        .gc_second (gc_second),
        .gc_third  (gc_third),
        .status    (status)
    );

endmodule

FILE: rtl/gccp_ctrl.sv
`include "assert_macros.svh"

module gccp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              last,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output gccp_pkg::dp_cmd_t cmd
);
    import gccp_pkg::*;

    state_t                 state_reg, state_next;
    div_sel_t               sel_reg, sel_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            sel_reg       <= DIV_ALL;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        cmd            = '0;
        cmd.sel        = sel_reg;
        case (state_reg)
            ST_RUN:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.count = 1'b1;
                    if (last)
                    begin
                        sel_next   = DIV_ALL;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (step_reg == STEP_BITS'(QUOT_BITS - 1))
                begin
                    cmd.store = 1'b1;
                    if (sel_reg == DIV_THIRD)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sel_next   = div_sel_t'(sel_reg + 2'd1);
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    `GCCP_ASSERT_NEXT(a_publish_sets_valid, clk, rst_n, cmd.publish, out_valid_reg)
    `GCCP_ASSERT_IMPL(a_held_word_kept, clk, rst_n, out_valid_reg && out_stall, !cmd.publish)
    `GCCP_ASSERT_IMPL(a_step_in_range, clk, rst_n, state_reg == ST_STEP, step_reg < STEP_BITS'(QUOT_BITS))

endmodule

FILE: rtl/gccp_datapath.sv
`include "assert_macros.svh"

module gccp_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  gccp_pkg::dp_cmd_t                    cmd,
    input  logic                                 cfg_write,
    input  logic [gccp_pkg::EN_BITS-1:0]         cfg_data,
    input  logic [gccp_pkg::BASE_BITS-1:0]       base,
    output logic [gccp_pkg::ALL_BITS-1:0]        gc_all,
    output logic [gccp_pkg::POS_BITS-1:0]        gc_first,
    output logic [gccp_pkg::POS_BITS-1:0]        gc_second,
    output logic [gccp_pkg::POS_BITS-1:0]        gc_third,
    output logic [gccp_pkg::STATUS_BITS-1:0]     status
);
    import gccp_pkg::*;

    logic [EN_BITS-1:0]      en_reg;
    logic [COUNT_BITS-1:0]   len_reg, len_next;
    logic [COUNT_BITS-1:0]   total_reg, total_next;
    logic [COUNT_BITS-1:0]   pos_reg [3];
    logic [COUNT_BITS-1:0]   pos_next [3];
    logic [1:0]              phase_reg, phase_next;
    logic                    sat_reg, sat_next;

    logic [COUNT_BITS-1:0]   rem_reg, rem_next;
    logic [QUOT_BITS-1:0]    lo_reg, lo_next;
    logic [QUOT_BITS-1:0]    quot_reg, quot_next;
    logic [QUOT_BITS-1:0]    res_reg [4];

    logic [ALL_BITS-1:0]     gc_all_reg, gc_all_next;
    logic [POS_BITS-1:0]     gc_first_reg, gc_first_next;
    logic [POS_BITS-1:0]     gc_second_reg, gc_second_next;
    logic [POS_BITS-1:0]     gc_third_reg, gc_third_next;
    status_t                 status_reg, status_next;

    logic [COUNT_BITS-1:0]   pos_sel;
    logic [NUM_BITS-1:0]     num;
    logic [COUNT_BITS:0]     trial;
    logic [COUNT_BITS:0]     diff;
    logic                    ge;
    logic                    vals_ok;

    // Running counts over the sequence; a full length counter freezes everything.
    always_comb
    begin
        len_next   = len_reg;
        total_next = total_reg;
        phase_next = phase_reg;
        sat_next   = sat_reg;
        for (int k = 0; k < 3; k++)
        begin
            pos_next[k] = pos_reg[k];
        end
        if (cmd.publish)
        begin
            len_next   = '0;
            total_next = '0;
            phase_next = '0;
            sat_next   = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                pos_next[k] = '0;
            end
        end
        else if (cmd.count)
        begin
            if (len_reg == COUNT_MAX)
            begin
                sat_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + 1'b1;
                if (is_gc(base))
                begin
                    total_next = total_reg + 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (phase_reg == 2'(k))
                        begin
                            pos_next[k] = pos_reg[k] + 1'b1;
                        end
                    end
                end
                phase_next = (phase_reg >= 2'd2) ? 2'd0 : phase_reg + 2'd1;
            end
        end
    end

    // Restoring divider: the quotient is below four, so the top of the dividend
    // already sits under the length and only the last QUOT_BITS bits are iterated.
    always_comb
    begin
        case (cmd.sel)
            DIV_FIRST:  pos_sel = pos_reg[0];
            DIV_SECOND: pos_sel = pos_reg[1];
            default:    pos_sel = pos_reg[2];
        endcase
        if (cmd.sel == DIV_ALL)
        begin
            num = NUM_BITS'(total_reg);
        end
        else
        begin
            num = (NUM_BITS'(pos_sel) << 1) + NUM_BITS'(pos_sel);
        end
        trial = {rem_reg, lo_reg[QUOT_BITS-1]};
        diff  = trial - {1'b0, len_reg};
        ge    = trial >= {1'b0, len_reg};

        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quot_next = quot_reg;
        if (cmd.load)
        begin
            rem_next  = num[NUM_BITS-1:2];
            lo_next   = {num[1:0], {FRAC_BITS{1'b0}}};
            quot_next = '0;
        end
        else if (cmd.step)
        begin
            rem_next  = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            lo_next   = {lo_reg[QUOT_BITS-2:0], 1'b0};
            quot_next = {quot_reg[QUOT_BITS-2:0], ge};
        end
    end

    always_comb
    begin
        vals_ok = (en_reg != '0) && (len_reg != '0);
        if (en_reg == '0)
        begin
            status_next = STATUS_NO_STAT;
        end
        else if (sat_reg)
        begin
            status_next = STATUS_SATURATED;
        end
        else if (len_reg == '0)
        begin
            status_next = STATUS_EMPTY;
        end
        else
        begin
            status_next = STATUS_OK;
        end
        gc_all_next    = (vals_ok && en_reg[0]) ? res_reg[DIV_ALL][ALL_BITS-1:0] : '0;
        gc_first_next  = (vals_ok && en_reg[1]) ? res_reg[DIV_FIRST] : '0;
        gc_second_next = (vals_ok && en_reg[2]) ? res_reg[DIV_SECOND] : '0;
        gc_third_next  = (vals_ok && en_reg[3]) ? res_reg[DIV_THIRD] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= EN_RESET;
            len_reg   <= '0;
            total_reg <= '0;
            phase_reg <= '0;
            sat_reg   <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                en_reg <= cfg_data;
            end
            len_reg   <= len_next;
            total_reg <= total_next;
            phase_reg <= phase_next;
            sat_reg   <= sat_next;
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k] <= pos_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        quot_reg <= quot_next;
        if (cmd.store)
        begin
            res_reg[cmd.sel] <= quot_next;
        end
        if (cmd.publish)
        begin
            gc_all_reg    <= gc_all_next;
            gc_first_reg  <= gc_first_next;
            gc_second_reg <= gc_second_next;
            gc_third_reg  <= gc_third_next;
            status_reg    <= status_next;
        end
    end

    assign gc_all    = gc_all_reg;
    assign gc_first  = gc_first_reg;
    assign gc_second = gc_second_reg;
    assign gc_third  = gc_third_reg;
    assign status    = status_reg;

    `GCCP_ASSERT_IMPL(a_rem_below_len, clk, rst_n, cmd.step && (len_reg != '0), rem_reg < len_reg)
    `GCCP_ASSERT_NEXT(a_saturation_flagged, clk, rst_n, cmd.count && (len_reg == COUNT_MAX), sat_reg)
    `GCCP_ASSERT_IMPL(a_len_frozen_in_div, clk, rst_n, cmd.step || cmd.load, len_next == len_reg)

endmodule
